// ===== rtl/core/fesgt_pkg.sv =====
// Package for the flow-export sequence gap tracker.
// Table size, status codes, field constants and the beat passed down the
// cell chain. No dependencies.
package fesgt_pkg;

    localparam int TABLE_ENTRIES = 16;

    localparam logic [7:0] UDP_PROTOCOL     = 8'd17;
    localparam logic [3:0] MIN_HEADER_WORDS = 4'd5;

    localparam logic [2:0] ST_SHORT     = 3'd0;
    localparam logic [2:0] ST_NOT_UDP   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FIRST     = 3'd3;
    localparam logic [2:0] ST_IN_ORDER  = 3'd4;
    localparam logic [2:0] ST_DUPLICATE = 3'd5;
    localparam logic [2:0] ST_GAP       = 3'd6;

    // One packet on its way through the slot cells.
    typedef struct packed {
        logic        valid;
        logic        done;    // status settled, later cells leave it alone
        logic [2:0]  status;
        logic [31:0] key;     // packed source id, zero for dropped packets
        logic [31:0] seq;
        logic [15:0] cnt;
        logic [31:0] pstart;
        logic [31:0] pend;
    } beat_t;

endpackage

// ===== rtl/core/fesgt_pkt_if.sv =====
// Input channel of the gap tracker: parsed export packet header.
// Valid/ready handshake; no dependencies.
interface fesgt_pkt_if;
    logic        valid;
    logic        ready;
    logic [3:0]  ip_header_words;
    logic [7:0]  ip_protocol;
    logic [15:0] dst_port;
    logic [7:0]  exporter_type;
    logic [7:0]  exporter_id;
    logic [31:0] first_seq;
    logic [15:0] record_count;

    modport source (output valid, ip_header_words, ip_protocol, dst_port, exporter_type,
                    exporter_id, first_seq, record_count, input ready);
    modport sink (input valid, ip_header_words, ip_protocol, dst_port, exporter_type,
                  exporter_id, first_seq, record_count, output ready);
endinterface

// ===== rtl/core/fesgt_res_if.sv =====
// Output channel of the gap tracker: one result per packet.
// Valid/ready handshake; no dependencies.
interface fesgt_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] piece_start;
    logic [31:0] piece_end;
    logic [31:0] source_id;

    modport source (output valid, status, piece_start, piece_end, source_id, input ready);
    modport sink (input valid, status, piece_start, piece_end, source_id, output ready);
endinterface

// ===== rtl/core/flow_export_sequence_gap_tracker.sv =====
// Top level of the flow-export sequence gap tracker: entry classification,
// a chain of fesgt_cell slots and the result register.
// Uses fesgt_pkg, fesgt_pkt_if, fesgt_res_if and fesgt_cell.
//
//   channel  | dir | beat
//   ---------+-----+-------------------------------------------------------
//   pkt      | in  | header words, protocol, port, exporter type/id, seq, count
//   result   | out | status, piece_start, piece_end, source_id
//
// Each packet walks one slot cell per cycle while the chain advances; its
// result is registered after the last cell, one per packet, in order.
// Beats enter every cycle while results are taken; a result held back by
// result.ready freezes the whole chain and drops pkt.ready.
// Reset clears all slots at once; no clearing pass.
module flow_export_sequence_gap_tracker (
    input  logic        clk,
    input  logic        rst_n,
    fesgt_pkt_if.sink   pkt,
    fesgt_res_if.source result
);

    fesgt_pkg::beat_t chain [fesgt_pkg::TABLE_ENTRIES + 1];
    fesgt_pkg::beat_t entry;
    fesgt_pkg::beat_t last_beat;

    logic        advance;
    logic        out_valid_reg;
    logic [2:0]  status_reg,  status_next;
    logic [31:0] pstart_reg,  pstart_next;
    logic [31:0] pend_reg,    pend_next;
    logic [31:0] sid_reg;

    assign advance   = !out_valid_reg || result.ready;
    assign pkt.ready = advance;

    always_comb
    begin
        entry        = '0;
        entry.valid  = pkt.valid;
        entry.seq    = pkt.first_seq;
        entry.cnt    = pkt.record_count;
        if (pkt.ip_header_words < fesgt_pkg::MIN_HEADER_WORDS)
        begin
            entry.done   = 1'b1;
            entry.status = fesgt_pkg::ST_SHORT;
        end
        else if (pkt.ip_protocol != fesgt_pkg::UDP_PROTOCOL)
        begin
            entry.done   = 1'b1;
            entry.status = fesgt_pkg::ST_NOT_UDP;
        end
        else
        begin
            entry.key = {pkt.exporter_id, pkt.exporter_type, pkt.dst_port};
        end
    end

    assign chain[0] = entry;

    for (genvar i = 0; i < fesgt_pkg::TABLE_ENTRIES; i++)
    begin : g_cell
        fesgt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .beat_in  (chain[i]),
            .beat_out (chain[i + 1])
        );
    end

    assign last_beat = chain[fesgt_pkg::TABLE_ENTRIES];

    // a beat that passed every slot unsettled found the table full
    always_comb
    begin
        status_next = last_beat.status;
        pstart_next = last_beat.pstart;
        pend_next   = last_beat.pend;
        if (!last_beat.done)
        begin
            status_next = fesgt_pkg::ST_FULL;
            pstart_next = 32'd0;
            pend_next   = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= last_beat.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
            pstart_reg <= pstart_next;
            pend_reg   <= pend_next;
            sid_reg    <= last_beat.key;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = status_reg;
    assign result.piece_start = pstart_reg;
    assign result.piece_end   = pend_reg;
    assign result.source_id   = sid_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> (out_valid_reg && $stable(status_reg)))
        else $error("held result changed");

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !pkt.ready)
        else $error("input taken while chain stalled");

    a_pieces_only_on_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != fesgt_pkg::ST_GAP) |->
        (pstart_reg == 32'd0 && pend_reg == 32'd0))
        else $error("piece fields set without a gap");

endmodule

// ===== rtl/core/fesgt_cell.sv =====
// One table slot of the gap tracker: holds a source's key and sequence state,
// settles the beat that matches or claims it, and registers the beat onward.
// Uses fesgt_pkg.
module fesgt_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  fesgt_pkg::beat_t  beat_in,
    output fesgt_pkg::beat_t  beat_out
);

    logic             used_reg,  used_next;
    logic [31:0]      key_reg,   key_next;
    logic [31:0]      seq_reg,   seq_next;
    logic [15:0]      count_reg, count_next;
    logic [31:0]      run_reg,   run_next;
    fesgt_pkg::beat_t beat_reg,  beat_next;

    logic        hit;
    logic [31:0] expect_seq;

    assign hit        = beat_in.valid && !beat_in.done &&
                        (!used_reg || (key_reg == beat_in.key));
    assign expect_seq = seq_reg + {16'b0, count_reg};

    always_comb
    begin
        used_next  = used_reg;
        key_next   = key_reg;
        seq_next   = seq_reg;
        count_next = count_reg;
        run_next   = run_reg;
        beat_next  = beat_in;
        if (hit)
        begin
            beat_next.done = 1'b1;
            if (!used_reg || count_reg == 16'd0)
            begin
                beat_next.status = fesgt_pkg::ST_FIRST;
            end
            else if (seq_reg == beat_in.seq)
            begin
                beat_next.status = fesgt_pkg::ST_DUPLICATE;
            end
            else if (expect_seq != beat_in.seq)
            begin
                beat_next.status = fesgt_pkg::ST_GAP;
                beat_next.pstart = run_reg;
                beat_next.pend   = expect_seq;
                run_next         = beat_in.seq;
            end
            else
            begin
                beat_next.status = fesgt_pkg::ST_IN_ORDER;
                if (run_reg == 32'd0)
                begin
                    run_next = beat_in.seq;
                end
            end
            // claim a free slot on first sight, or update a matched slot's state
            used_next  = 1'b1;
            key_next   = beat_in.key;
            seq_next   = beat_in.seq;
            count_next = beat_in.cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            count_reg <= 16'd0;
            run_reg   <= 32'd0;
            beat_reg  <= '0;
        end
        else if (advance)
        begin
            used_reg  <= used_next;
            count_reg <= count_next;
            run_reg   <= run_next;
            beat_reg  <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_reg <= key_next;
            seq_reg <= seq_next;
        end
    end

    assign beat_out = beat_reg;

    a_used_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg |=> used_reg)
        else $error("slot lost its used bit");

    a_settled_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && beat_in.valid && beat_in.done) |=>
        (beat_out.done && beat_out.status == $past(beat_in.status)))
        else $error("settled beat changed in cell");

    a_claim_first: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && beat_in.valid && !beat_in.done && !used_reg) |=>
        (used_reg && beat_out.done && beat_out.status == fesgt_pkg::ST_FIRST))
        else $error("free slot did not claim new source");

endmodule
